FILE: sv/assert_macros.svh
// assertion macros used by the button remapper rtl
// expects signals named clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BREA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define BREA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BREA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/brea_pkg.sv
// shared types and constants of the button remapper
// no dependencies
package brea_pkg;

  localparam int MAX_BUTTONS  = 12;
  localparam int KEY_CODE_W   = 8;
  localparam int FIRE_BUTTON  = 5;
  localparam int LIMIT_NORMAL = 15;
  localparam int LIMIT_FAST   = 7;
  localparam int TICK_W       = 5;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int MAP_HI_W     = 32;
  localparam int MODE_W       = 2;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AF_MODE = 2'd2;

  // autofire modes, the spare code behaves as none
  localparam logic [MODE_W-1:0] AF_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] AF_NORMAL = 2'd1;
  localparam logic [MODE_W-1:0] AF_FAST   = 2'd2;

  // item opcodes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [MAX_BUTTONS-1:0][KEY_CODE_W-1:0] map;
    logic [MODE_W-1:0]                      af_mode;
  } cfg_t;

  typedef struct packed {
    logic                   opcode;
    logic [MAX_BUTTONS-1:0] buttons;
    logic [KEY_CODE_W-1:0]  key_index;
  } item_t;

  typedef struct packed {
    logic fire_forced_off;
    logic just_released;
    logic just_pressed;
    logic pressed;
  } res_t;

endpackage

FILE: sv/brea_cfg.sv
// configuration registers: button mappings and autofire mode
// depends on brea_pkg
module brea_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [brea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brea_pkg::CFG_DATA_W-1:0] cfg_data,
  output brea_pkg::cfg_t                  cfg
);
  import brea_pkg::*;

  logic [CFG_DATA_W-1:0] map_lo_r;
  logic [MAP_HI_W-1:0]   map_hi_r;
  logic [MODE_W-1:0]     mode_r;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register write on each transfer, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_lo_r <= '0;
      map_hi_r <= '0;
      mode_r   <= AF_NONE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAP_LO:  map_lo_r <= cfg_data;
        REG_MAP_HI:  map_hi_r <= cfg_data[MAP_HI_W-1:0];
        REG_AF_MODE: mode_r   <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // split the mapping words into one byte per button
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      cfg.map[b] = map_lo_r[b*KEY_CODE_W +: KEY_CODE_W];
    end
    for (int b = 0; b < MAX_BUTTONS - 8; b++) begin
      cfg.map[b+8] = map_hi_r[b*KEY_CODE_W +: KEY_CODE_W];
    end
    cfg.af_mode = mode_r;
  end

endmodule

FILE: sv/brea_core.sv
// key state flops, edge flags, autofire counter and query read-out
// depends on brea_pkg and assert_macros.svh
`include "assert_macros.svh"
module brea_core #(
  parameter int NUM_KEYS    = 256,
  parameter int NUM_BUTTONS = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  brea_pkg::cfg_t  cfg,
  input  brea_pkg::item_t item,
  input  logic            adv,
  output brea_pkg::res_t  res
);
  import brea_pkg::*;

  localparam int KEY_W = $clog2(NUM_KEYS);

  logic [NUM_KEYS-1:0] down_r, went_down_r, went_up_r;
  logic [NUM_KEYS-1:0] down_raw, down_nxt, went_down_nxt, went_up_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt, tick_inc;
  logic                fire_en, forced, is_frame, in_range;
  logic [KEY_W-1:0]    sel;

  assign is_frame = (item.opcode == OP_FRAME);

  // mark every key named by a pressed button
  always_comb begin
    down_raw = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (item.buttons[b] && (cfg.map[b] == KEY_CODE_W'(k))) begin
          down_raw[k] = 1'b1;
        end
      end
    end
  end

  // autofire tick and forced release of the fire key
  assign fire_en  = (NUM_BUTTONS > FIRE_BUTTON) && item.buttons[FIRE_BUTTON]
                    && ((cfg.af_mode == AF_NORMAL) || (cfg.af_mode == AF_FAST));
  assign tick_inc = tick_r + TICK_W'(1);
  assign forced   = fire_en
                    && (((cfg.af_mode == AF_NORMAL) && (tick_inc > TICK_W'(LIMIT_NORMAL)))
                     || ((cfg.af_mode == AF_FAST) && (tick_inc > TICK_W'(LIMIT_FAST))));
  assign tick_nxt = fire_en ? (forced ? '0 : tick_inc) : tick_r;

  always_comb begin
    down_nxt = down_raw;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (forced && (cfg.map[FIRE_BUTTON] == KEY_CODE_W'(k))) begin
        down_nxt[k] = 1'b0;
      end
    end
  end

  // edges against the previous frame
  assign went_down_nxt = down_nxt & ~down_r;
  assign went_up_nxt   = ~down_nxt & down_r;

  // state moves on when a frame item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_r      <= '0;
      went_down_r <= '0;
      went_up_r   <= '0;
      tick_r      <= '0;
    end else if (adv && is_frame) begin
      down_r      <= down_nxt;
      went_down_r <= went_down_nxt;
      went_up_r   <= went_up_nxt;
      tick_r      <= tick_nxt;
    end
  end

  // query read-out, keys beyond the store read as zero
  assign in_range = ({1'b0, item.key_index} < (KEY_CODE_W + 1)'(NUM_KEYS));
  assign sel      = item.key_index[KEY_W-1:0];

  always_comb begin
    res = '0;
    if (is_frame) begin
      res.fire_forced_off = forced;
    end else if (in_range) begin
      res.pressed       = down_r[sel];
      res.just_pressed  = went_down_r[sel];
      res.just_released = went_up_r[sel];
    end
  end

  `BREA_ASSERT(a_tick_bound, tick_r <= TICK_W'(LIMIT_NORMAL), "autofire tick out of range")
  `BREA_ASSERT(a_edge_excl, (went_down_r & went_up_r) == '0, "key both pressed and released")
  `BREA_ASSERT(a_down_edge, (went_down_r & ~down_r) == '0, "just pressed key not down")
  `BREA_ASSERT_NEXT(a_force_clr, adv && is_frame && forced, tick_r == '0, "tick not cleared")
  `BREA_ASSERT_IMPL(a_query_flag, !is_frame, !res.fire_forced_off, "query reports forced release")

endmodule

FILE: sv/button_remap_edge_autofire.sv
// Button remapper with edge flags and autofire. Accepts one item every clock cycle while
// the result channel is not stalled; an item passes from the input register through a single
// pass of compare logic across all keys and buttons into the result register. The
// throughput is set by the key update, which writes all key flags in
// parallel; a query issued right after a frame sees that frame's state. Key flags live
// in flops that reset clears at once, so there is no clearing pass after reset.
// Configuration writes are taken at any time but belong to idle periods.
// depends on brea_pkg, brea_cfg and brea_core
module button_remap_edge_autofire #(
  parameter int NUM_KEYS    = 256,
  parameter int NUM_BUTTONS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [brea_pkg::IN_TDATA_W-1:0]    in_tdata,  // buttons[11:0], key_index[19:12], zero
  input  logic                               in_tuser,  // opcode
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [brea_pkg::OUT_TDATA_W-1:0]   out_tdata, // pressed, just_pressed,
                                                        // just_released, fire_forced_off, zero
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [brea_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [brea_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import brea_pkg::*;

  cfg_t  cfg;
  item_t s_item_r;
  res_t  res, out_res_r;
  logic  s_valid_r, out_valid_r, out_free, adv, in_acc;

  brea_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  brea_core #(
    .NUM_KEYS    (NUM_KEYS),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (s_item_r),
    .adv   (adv),
    .res   (res)
  );

  // handshake between input register and result register
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s_valid_r && out_free;
  assign in_tready = !s_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s_valid_r <= 1'b1;
      end else if (adv) begin
        s_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_item_r.opcode    <= in_tuser;
      s_item_r.buttons   <= in_tdata[MAX_BUTTONS-1:0];
      s_item_r.key_index <= in_tdata[MAX_BUTTONS +: KEY_CODE_W];
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.fire_forced_off, out_res_r.just_released,
                       out_res_r.just_pressed, out_res_r.pressed};

endmodule
